// ===== rtl/core/erl_pkg.sv =====
`default_nettype none

package erl_pkg;

  // Operation codes carried in s_axis_tuser
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_AGE    = 2'd1;
  localparam logic [1:0] OP_SINCE  = 2'd2;

  // One stored log entry
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tstamp;
    logic [1:0]  level;
    logic [15:0] code;
  } erl_entry_t;

  // One result transaction
  typedef struct packed {
    logic        found;
    logic [31:0] seq;
    logic [31:0] tstamp;
    logic [1:0]  level;
    logic [15:0] code;
    logic [8:0]  fill;
    logic [31:0] new_seq;
    logic        last;
  } erl_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/erl_ram.sv =====
`default_nettype none

// Single-port RAM with registered read
module erl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/event_ring_log_core.sv =====
// Event ring log: append, read by age and read since sequence.
// Append, read-by-age miss, no-op and a read since with a zero limit or an empty
// log: result registered straight from idle. Read by age with a hit: RAM read
// in idle, registered data sent from the age state. Read since: a read and an
// evaluate state per entry walked, then a flush, paced by the single RAM port;
// result back-pressure stretches any of these while the output register is full.
// Reset (async, active low) clears pointers, fill and sequence; RAM is not cleared.
`default_nettype none

module event_ring_log_core
  import erl_pkg::*;
#(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration: capacity
  input  wire logic         cfg_we_i,
  input  wire logic [8:0]   cfg_wdata_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] event_time, [33:32] level, [49:34] code, [57:50] age_index,
  // [89:58] since_seq, [96:90] max_out, [103:97] zero
  input  wire logic [103:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]   s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] entry_seq, [63:32] entry_time, [65:64] entry_level,
  // [81:66] entry_code, [90:82] fill, [122:91] new_seq, [127:123] zero
  output logic [127:0]      m_axis_tdata,
  // [0] found
  output logic [0:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_BURST + 1);
  localparam int unsigned DW = ((CW > 8) ? CW : 8) + 1;
  localparam int unsigned EW = $bits(erl_entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AGE   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EV    = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  // Input fields
  logic [31:0] in_time;
  logic [1:0]  in_level;
  logic [15:0] in_code;
  logic [7:0]  in_age;
  logic [31:0] in_since;
  logic [6:0]  in_max;
  assign in_time  = s_axis_tdata[31:0];
  assign in_level = s_axis_tdata[33:32];
  assign in_code  = s_axis_tdata[49:34];
  assign in_age   = s_axis_tdata[57:50];
  assign in_since = s_axis_tdata[89:58];
  assign in_max   = s_axis_tdata[96:90];

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [31:0]   lseq_q, lseq_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] lim_q, lim_d;
  logic [31:0]   since_q, since_d;
  logic          pend_vld_q, pend_vld_d;
  erl_entry_t    pend_q, pend_d;
  logic          m_valid_q;
  erl_result_t   res_q;

  logic          out_free;
  logic          s_acc;
  logic          push;
  erl_result_t   push_rec;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  erl_entry_t    ram_wdata;
  logic [EW-1:0] ram_rdata;
  erl_entry_t    rd_entry;

  logic [DW-1:0] age_diff;
  logic [DW-1:0] age_wrap;
  logic [AW-1:0] age_slot;
  logic          age_hit;
  logic [NW-1:0] in_lim;
  logic [CW-1:0] ptr_inc;
  logic [AW-1:0] ptr_next;
  logic [CW-1:0] wp_inc;
  logic [AW-1:0] wp_next;
  logic          match;
  logic [8:0]    fill9;

  assign out_free      = ~m_valid_q | m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) & out_free;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign rd_entry      = erl_entry_t'(ram_rdata);
  assign fill9         = 9'(fill_q);

  // Slot of the entry age_index back from the newest, wrapped once
  assign age_diff = DW'(wp_q) - DW'(1) - DW'(in_age);
  assign age_wrap = age_diff[DW-1] ? (age_diff + DW'(cap_q)) : age_diff;
  assign age_slot = age_wrap[AW-1:0];
  assign age_hit  = DW'(in_age) < DW'(fill_q);

  // Burst limit saturated to MAX_BURST
  assign in_lim = (in_max > 7'(MAX_BURST)) ? NW'(MAX_BURST) : NW'(in_max);

  // Ring pointer increments modulo capacity
  assign ptr_inc  = CW'(ptr_q) + CW'(1);
  assign ptr_next = (ptr_inc == cap_q) ? '0 : ptr_inc[AW-1:0];
  assign wp_inc   = CW'(wp_q) + CW'(1);
  assign wp_next  = (wp_inc == cap_q) ? '0 : wp_inc[AW-1:0];

  assign match = rd_entry.seq > since_q;

  // Entry RAM
  erl_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cap_d      = cap_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    lseq_d     = lseq_q;
    ptr_d      = ptr_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    since_d    = since_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    push       = 1'b0;
    push_rec   = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = ptr_q;
    ram_wdata.seq    = lseq_q + 32'd1;
    ram_wdata.tstamp = in_time;
    ram_wdata.level  = in_level;
    ram_wdata.code   = in_code;

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          push_rec.fill = fill9;
          push_rec.last = 1'b1;
          case (s_axis_tuser)
            OP_APPEND: begin
              ram_we   = 1'b1;
              ram_addr = wp_q;
              lseq_d   = lseq_q + 32'd1;
              wp_d     = wp_next;
              if (fill_q < cap_q) begin
                fill_d = fill_q + CW'(1);
              end
              push            = 1'b1;
              push_rec.found  = 1'b1;
              push_rec.seq    = lseq_q + 32'd1;
              push_rec.tstamp = in_time;
              push_rec.level  = in_level;
              push_rec.code   = in_code;
              push_rec.fill   = 9'(fill_d);
            end
            OP_AGE: begin
              if (age_hit) begin
                ram_re   = 1'b1;
                ram_addr = age_slot;
                state_d  = ST_AGE;
              end else begin
                push = 1'b1;
              end
            end
            OP_SINCE: begin
              if ((in_lim == '0) || (fill_q == '0)) begin
                push             = 1'b1;
                push_rec.new_seq = in_since;
              end else begin
                ptr_d      = (fill_q == cap_q) ? wp_q : '0;
                rem_d      = fill_q;
                cnt_d      = '0;
                lim_d      = in_lim;
                since_d    = in_since;
                pend_vld_d = 1'b0;
                state_d    = ST_RD;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end

      ST_AGE: begin
        if (out_free) begin
          push            = 1'b1;
          push_rec.found  = 1'b1;
          push_rec.seq    = rd_entry.seq;
          push_rec.tstamp = rd_entry.tstamp;
          push_rec.level  = rd_entry.level;
          push_rec.code   = rd_entry.code;
          push_rec.fill   = fill9;
          push_rec.last   = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      ST_RD: begin
        ram_re  = 1'b1;
        ptr_d   = ptr_next;
        rem_d   = rem_q - CW'(1);
        state_d = ST_EV;
      end

      ST_EV: begin
        if (match) begin
          // Earlier match goes out first; it cannot be the final one
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              push             = 1'b1;
              push_rec.found   = 1'b1;
              push_rec.seq     = pend_q.seq;
              push_rec.tstamp  = pend_q.tstamp;
              push_rec.level   = pend_q.level;
              push_rec.code    = pend_q.code;
              push_rec.fill    = fill9;
              push_rec.new_seq = pend_q.seq;
            end
            pend_vld_d = 1'b1;
            pend_d     = rd_entry;
            cnt_d      = cnt_q + NW'(1);
            if ((cnt_d == lim_q) || (rem_q == '0)) begin
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_RD;
            end
          end
        end else if (rem_q == '0) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_RD;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push          = 1'b1;
          push_rec.fill = fill9;
          push_rec.last = 1'b1;
          if (pend_vld_q) begin
            push_rec.found   = 1'b1;
            push_rec.seq     = pend_q.seq;
            push_rec.tstamp  = pend_q.tstamp;
            push_rec.level   = pend_q.level;
            push_rec.code    = pend_q.code;
            push_rec.new_seq = pend_q.seq;
          end else begin
            push_rec.new_seq = since_q;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Capacity write empties the log, clamped to 1..DEPTH
    if (cfg_we_i) begin
      if (cfg_wdata_i == 9'd0) begin
        cap_d = CW'(1);
      end else if (32'(cfg_wdata_i) > DEPTH) begin
        cap_d = CW'(DEPTH);
      end else begin
        cap_d = CW'(cfg_wdata_i);
      end
      wp_d   = '0;
      fill_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cap_q      <= CW'(DEPTH);
      wp_q       <= '0;
      fill_q     <= '0;
      lseq_q     <= '0;
      ptr_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      lim_q      <= '0;
      pend_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cap_q      <= cap_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      lseq_q     <= lseq_d;
      ptr_q      <= ptr_d;
      rem_q      <= rem_d;
      cnt_q      <= cnt_d;
      lim_q      <= lim_d;
      pend_vld_q <= pend_vld_d;
      if (out_free) begin
        m_valid_q <= push;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    since_q <= since_d;
    pend_q  <= pend_d;
    if (out_free && push) begin
      res_q <= push_rec;
    end
  end

  // Result port
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.found;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {5'b0, res_q.new_seq, res_q.fill, res_q.code, res_q.level,
                          res_q.tstamp, res_q.seq};

endmodule

`default_nettype wire
